// ----- hw/rtl/oad_pkg.sv -----
// ----------------------------------------------------------------------------
// oad_pkg
// Types and constants shared by the obstacle avoidance drive controller.
// ----------------------------------------------------------------------------
package oad_pkg;

   localparam logic [31:0] WAIT_MS   = 32'd120;
   localparam logic [7:0]  MIN_SPEED = 8'd55;

   // quotient bits of the speed interpolation divide, one per cycle
   localparam int DIV_STEPS = 8;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2,
      OP_ESTOP  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      MODE_STOP  = 4'd0,
      MODE_FWD   = 4'd1,
      MODE_SLOW  = 4'd2,
      MODE_OBST  = 4'd3,
      MODE_REV   = 4'd4,
      MODE_LEFT  = 4'd5,
      MODE_RIGHT = 4'd6,
      MODE_BLOCK = 4'd7,
      MODE_EMERG = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_BRAKE = 3'd1,
      CMD_FWD   = 3'd2,
      CMD_BACK  = 3'd3,
      CMD_ROTL  = 3'd4,
      CMD_ROTR  = 3'd5,
      CMD_EMERG = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_MIN_DIST    = 3'd0,
      CSR_SLOW_DIST   = 3'd1,
      CSR_CRUISE_SPD  = 3'd2,
      CSR_REV_SPD     = 3'd3,
      CSR_TURN_SPD    = 3'd4,
      CSR_REV_TIME    = 3'd5,
      CSR_TURN_TIME   = 3'd6,
      CSR_STUCK_TIME  = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      SPD_ZERO,
      SPD_CRUISE,
      SPD_REV,
      SPD_TURN,
      SPD_INTERP
   } spd_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      op_type      opcode;
      logic [31:0] now_ms;
      logic [15:0] center_dist;
      logic        center_healthy;
      logic        center_valid;
      logic [15:0] left_dist;
      logic        left_valid;
      logic [15:0] right_dist;
      logic        right_valid;
   } req_type;

   typedef struct packed {
      mode_type    mode;
      cmd_type     motor_cmd;
      logic [7:0]  motor_speed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decide;
      logic mul;
      logic div_step;
      logic commit;
   } oad_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic out_free;
   } oad_status_type;

endpackage

// ----- hw/rtl/oad_ctrl.sv -----
// ----------------------------------------------------------------------------
// oad_ctrl
// Sequencer: capture, decide, multiply, optional divide, then commit.
// ----------------------------------------------------------------------------
module oad_ctrl
   import oad_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  oad_status_type status,
   output oad_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           div_last;

   assign div_last = (cnt_ff == 3'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_MUL;
         ST_MUL:    state_in = status.need_div ? ST_DIV : ST_COMMIT;
         ST_DIV:    if (div_last) state_in = ST_COMMIT;
         ST_COMMIT: if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECIDE: cmd.decide = 1'b1;
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
         end
         ST_COMMIT: cmd.commit = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/oad_dp.sv -----
// ----------------------------------------------------------------------------
// oad_dp
// Datapath: settings, drive state, mode decision, speed interpolation
// (multiply then restoring divide, one quotient bit a cycle) and result register.
// ----------------------------------------------------------------------------
module oad_dp
   import oad_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [2:0]     csr_index,
   input  logic [15:0]    csr_wdata,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data,
   input  oad_cmd_type    cmd,
   output oad_status_type status
);

   typedef struct packed {
      mode_type    mode;
      cmd_type     cmd;
      spd_sel_type spd;
      logic        prog;
      logic        rtl_we;
      logic        rtl_val;
   } dec_type;

   // settings
   logic [15:0] min_dist_ff, slow_dist_ff, rev_time_ff, turn_time_ff, stuck_time_ff;
   logic [7:0]  cruise_ff, rev_spd_ff, turn_spd_ff;

   // drive state
   mode_type    mode_ff;
   logic [31:0] entered_ff, prog_ff;
   logic        rtl_ff;

   // working registers
   req_type     item_ff;
   dec_type     dec_ff, dec_in;
   logic [15:0] diff_ff, den_ff;
   logic [7:0]  span_ff;
   logic [23:0] rem_ff;
   logic [22:0] den_sh_ff;
   logic [7:0]  quot_ff;
   rsp_type     rsp_data_ff;
   logic        rsp_valid_ff;

   logic [15:0] l_dist, r_dist;
   logic [31:0] elapsed, since_prog;
   logic [7:0]  speed;
   logic        out_free;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.out_free = out_free;
   assign status.need_div = (dec_ff.spd == SPD_INTERP);

   assign l_dist     = item_ff.left_valid  ? item_ff.left_dist  : '0;
   assign r_dist     = item_ff.right_valid ? item_ff.right_dist : '0;
   assign elapsed    = item_ff.now_ms - entered_ff;
   assign since_prog = item_ff.now_ms - prog_ff;

   // mode decision for the captured transaction
   always_comb begin
      dec_in         = '0;
      dec_in.mode    = mode_ff;
      dec_in.cmd     = CMD_NONE;
      dec_in.spd     = SPD_ZERO;
      unique case (item_ff.opcode)
         OP_START: begin
            dec_in.cmd  = CMD_BRAKE;
            dec_in.mode = MODE_STOP;
            dec_in.prog = 1'b1;
         end
         OP_STOP: begin
            dec_in.cmd  = CMD_BRAKE;
            dec_in.mode = MODE_STOP;
         end
         OP_ESTOP: begin
            dec_in.cmd  = CMD_EMERG;
            dec_in.mode = MODE_EMERG;
         end
         OP_UPDATE: begin
            if (mode_ff == MODE_EMERG) begin
               dec_in.cmd = CMD_NONE;
            end else if (!item_ff.center_healthy || !item_ff.center_valid) begin
               dec_in.cmd  = CMD_BRAKE;
               dec_in.mode = MODE_BLOCK;
            end else begin
               unique case (mode_ff)
                  MODE_STOP: begin
                     if (item_ff.center_dist > min_dist_ff) begin
                        dec_in.mode = MODE_FWD;
                        dec_in.cmd  = CMD_FWD;
                        dec_in.spd  = SPD_CRUISE;
                     end else begin
                        dec_in.mode = MODE_OBST;
                        dec_in.cmd  = CMD_BRAKE;
                     end
                  end
                  MODE_FWD: begin
                     if (item_ff.center_dist <= min_dist_ff) begin
                        dec_in.cmd  = CMD_BRAKE;
                        dec_in.mode = MODE_OBST;
                     end else if (item_ff.center_dist <= slow_dist_ff) begin
                        dec_in.mode = MODE_SLOW;
                     end else begin
                        dec_in.cmd  = CMD_FWD;
                        dec_in.spd  = SPD_CRUISE;
                        dec_in.prog = 1'b1;
                     end
                  end
                  MODE_SLOW: begin
                     if (item_ff.center_dist <= min_dist_ff) begin
                        dec_in.cmd  = CMD_BRAKE;
                        dec_in.mode = MODE_OBST;
                     end else if (item_ff.center_dist > slow_dist_ff) begin
                        dec_in.mode = MODE_FWD;
                     end else begin
                        dec_in.cmd = CMD_FWD;
                        dec_in.spd = SPD_INTERP;
                     end
                  end
                  MODE_OBST: begin
                     if (elapsed >= WAIT_MS) begin
                        if (l_dist < min_dist_ff && r_dist < min_dist_ff) begin
                           dec_in.rtl_we  = 1'b1;
                           dec_in.rtl_val = (l_dist >= r_dist);
                           dec_in.mode    = MODE_REV;
                           dec_in.cmd     = CMD_BACK;
                           dec_in.spd     = SPD_REV;
                        end else if (l_dist >= r_dist) begin
                           dec_in.mode = MODE_LEFT;
                           dec_in.cmd  = CMD_ROTL;
                           dec_in.spd  = SPD_TURN;
                        end else begin
                           dec_in.mode = MODE_RIGHT;
                           dec_in.cmd  = CMD_ROTR;
                           dec_in.spd  = SPD_TURN;
                        end
                     end
                  end
                  MODE_REV: begin
                     if (elapsed >= {16'd0, rev_time_ff}) begin
                        dec_in.mode = rtl_ff ? MODE_LEFT : MODE_RIGHT;
                        dec_in.cmd  = rtl_ff ? CMD_ROTL : CMD_ROTR;
                        dec_in.spd  = SPD_TURN;
                     end
                  end
                  MODE_LEFT, MODE_RIGHT: begin
                     if (elapsed >= {16'd0, turn_time_ff}) begin
                        dec_in.cmd  = CMD_BRAKE;
                        dec_in.mode = MODE_STOP;
                     end
                  end
                  MODE_BLOCK: begin
                     dec_in.cmd = CMD_BRAKE;
                     if (item_ff.center_dist > min_dist_ff) dec_in.mode = MODE_STOP;
                  end
                  default: ;
               endcase
               // no forward progress for too long
               if (dec_in.mode == MODE_FWD && item_ff.center_dist <= slow_dist_ff &&
                   since_prog > {16'd0, stuck_time_ff}) begin
                  dec_in.cmd  = CMD_BRAKE;
                  dec_in.spd  = SPD_ZERO;
                  dec_in.mode = MODE_BLOCK;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (dec_ff.spd)
         SPD_CRUISE: speed = cruise_ff;
         SPD_REV:    speed = rev_spd_ff;
         SPD_TURN:   speed = turn_spd_ff;
         SPD_INTERP: speed = MIN_SPEED + quot_ff;
         default:    speed = '0;
      endcase
   end

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff   <= 16'd320;
         slow_dist_ff  <= 16'd800;
         cruise_ff     <= 8'd160;
         rev_spd_ff    <= 8'd140;
         turn_spd_ff   <= 8'd150;
         rev_time_ff   <= 16'd600;
         turn_time_ff  <= 16'd450;
         stuck_time_ff <= 16'd5000;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIN_DIST:   min_dist_ff   <= csr_wdata;
            CSR_SLOW_DIST:  slow_dist_ff  <= csr_wdata;
            CSR_CRUISE_SPD: cruise_ff     <= csr_wdata[7:0];
            CSR_REV_SPD:    rev_spd_ff    <= csr_wdata[7:0];
            CSR_TURN_SPD:   turn_spd_ff   <= csr_wdata[7:0];
            CSR_REV_TIME:   rev_time_ff   <= csr_wdata;
            CSR_TURN_TIME:  turn_time_ff  <= csr_wdata;
            CSR_STUCK_TIME: stuck_time_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // drive state, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STOP;
         entered_ff <= '0;
         prog_ff    <= '0;
         rtl_ff     <= 1'b0;
      end else if (cmd.commit) begin
         mode_ff <= dec_ff.mode;
         if (dec_ff.mode != mode_ff) entered_ff <= item_ff.now_ms;
         if (dec_ff.prog) prog_ff <= item_ff.now_ms;
         if (dec_ff.rtl_we) rtl_ff <= dec_ff.rtl_val;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      if (cmd.decide) begin
         dec_ff  <= dec_in;
         diff_ff <= item_ff.center_dist - min_dist_ff;
         den_ff  <= slow_dist_ff - min_dist_ff;
         span_ff <= (cruise_ff > MIN_SPEED) ? cruise_ff - MIN_SPEED : '0;
      end
      if (cmd.mul) begin
         rem_ff    <= diff_ff * span_ff;
         den_sh_ff <= {den_ff, 7'd0};
         quot_ff   <= '0;
      end
      if (cmd.div_step) begin
         if ({1'b0, den_sh_ff} <= rem_ff) begin
            rem_ff  <= rem_ff - {1'b0, den_sh_ff};
            quot_ff <= {quot_ff[6:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[6:0], 1'b0};
         end
         den_sh_ff <= {1'b0, den_sh_ff[22:1]};
      end
      if (cmd.commit) begin
         rsp_data_ff.mode        <= dec_ff.mode;
         rsp_data_ff.motor_cmd   <= dec_ff.cmd;
         rsp_data_ff.motor_speed <= speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/obstacle_avoid_drive_fsm_top.sv -----
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm_top
// Rover obstacle avoidance drive controller: sequencer plus datapath.
// ----------------------------------------------------------------------------
// sequence: each accepted transaction passes decide, multiply and commit; while
//   slowing, speed interpolation adds a restoring divide before commit
// flow: the sequencer takes one transaction at a time and a stalled result
//   holds it in commit
// reset: synchronous, restores register defaults and stop mode, no result pending
module obstacle_avoid_drive_fsm_top
   import oad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   oad_cmd_type    cmd;
   oad_status_type status;

   oad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   oad_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- hw/rtl/oad_checker.sv -----
// ----------------------------------------------------------------------------
// oad_checker
// Port-level checks for the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
module oad_checker
   import oad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one transaction at a time: busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a transaction is in flight");

   // stop-type commands carry no speed
   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.motor_cmd == CMD_NONE || rsp_data.motor_cmd == CMD_BRAKE ||
                    rsp_data.motor_cmd == CMD_EMERG) |-> rsp_data.motor_speed == 8'd0)
      else $error("speed given with a stop command");

   // emergency command always lands in emergency mode
   a_emerg_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motor_cmd == CMD_EMERG |-> rsp_data.mode == MODE_EMERG)
      else $error("emergency command outside emergency mode");

endmodule

bind obstacle_avoid_drive_fsm_top oad_checker u_oad_checker (.*);

// ----- tb/sv/obstacle_avoid_drive_fsm_top_test.sv -----
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm_top_test
// Self-checking bench for the rover obstacle avoidance drive controller.
// A directed table walks the mode sequence, emergency latching, sensor faults,
// time wrap and the stuck timeout. Random traffic then runs under several
// register settings. Results are checked against a behavioural predictor or a fixed row.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_fsm_top_test;
   import oad_pkg::*;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 147;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } step_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_we    = 1'b0;
   csr_idx_type csr_index = CSR_MIN_DIST;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   req_type     req_data  = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;

   // predictor registers and state
   logic [15:0] min_dist, slow_dist, rev_time, turn_time, stuck_time;
   logic [7:0]  cruise_spd, rev_spd, turn_spd;
   mode_type    cur_mode;
   logic [31:0] mode_since, progress_at;
   logic        back_then_left;

   rsp_type      pending_rsp[$];
   step_row_type plan[$];
   logic [31:0]  stamp;
   bit           calm;
   bit [8:0]     modes_hit;
   int           stall_left;
   int           faults;
   int           checked;
   int           sent;
   int           cycles;

   obstacle_avoid_drive_fsm_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void set_mode(input mode_type m, input logic [31:0] t);
      if (cur_mode != m) begin
         cur_mode   = m;
         mode_since = t;
      end
   endfunction

   function automatic rsp_type drive_decision(input req_type q);
      rsp_type     a;
      logic [15:0] lft;
      logic [15:0] rgt;
      logic [31:0] cc;
      logic [31:0] el;
      logic [31:0] span;
      logic [31:0] den;
      logic [31:0] add;
      a.motor_cmd   = CMD_NONE;
      a.motor_speed = 8'd0;
      lft = q.left_valid  ? q.left_dist  : 16'd0;
      rgt = q.right_valid ? q.right_dist : 16'd0;
      cc  = {16'd0, q.center_dist};
      case (q.opcode)
         OP_START: begin
            a.motor_cmd = CMD_BRAKE;
            progress_at = q.now_ms;
            set_mode(MODE_STOP, q.now_ms);
         end
         OP_STOP: begin
            a.motor_cmd = CMD_BRAKE;
            set_mode(MODE_STOP, q.now_ms);
         end
         OP_ESTOP: begin
            a.motor_cmd = CMD_EMERG;
            set_mode(MODE_EMERG, q.now_ms);
         end
         default: begin
            if (cur_mode == MODE_EMERG) begin
               // latched until start or stop
            end else if (!q.center_healthy || !q.center_valid) begin
               a.motor_cmd = CMD_BRAKE;
               set_mode(MODE_BLOCK, q.now_ms);
            end else begin
               el = q.now_ms - mode_since;
               case (cur_mode)
                  MODE_STOP: begin
                     if (cc > min_dist) begin
                        set_mode(MODE_FWD, q.now_ms);
                        a.motor_cmd   = CMD_FWD;
                        a.motor_speed = cruise_spd;
                     end else begin
                        set_mode(MODE_OBST, q.now_ms);
                        a.motor_cmd = CMD_BRAKE;
                     end
                  end
                  MODE_FWD: begin
                     if (cc <= min_dist) begin
                        a.motor_cmd = CMD_BRAKE;
                        set_mode(MODE_OBST, q.now_ms);
                     end else if (cc <= slow_dist) begin
                        set_mode(MODE_SLOW, q.now_ms);
                     end else begin
                        a.motor_cmd   = CMD_FWD;
                        a.motor_speed = cruise_spd;
                        progress_at   = q.now_ms;
                     end
                  end
                  MODE_SLOW: begin
                     if (cc <= min_dist) begin
                        a.motor_cmd = CMD_BRAKE;
                        set_mode(MODE_OBST, q.now_ms);
                     end else if (cc > slow_dist) begin
                        set_mode(MODE_FWD, q.now_ms);
                     end else begin
                        // linear ramp from the floor speed up to cruise
                        span = (cruise_spd > MIN_SPEED) ? 32'(cruise_spd - MIN_SPEED) : 32'd0;
                        den  = 32'(slow_dist) - 32'(min_dist);
                        add  = (den != 0) ? ((cc - 32'(min_dist)) * span) / den : 32'd0;
                        a.motor_cmd   = CMD_FWD;
                        a.motor_speed = 8'(32'(MIN_SPEED) + add);
                     end
                  end
                  MODE_OBST: begin
                     if (el >= WAIT_MS) begin
                        if (lft < min_dist && rgt < min_dist) begin
                           back_then_left = (lft >= rgt);
                           set_mode(MODE_REV, q.now_ms);
                           a.motor_cmd   = CMD_BACK;
                           a.motor_speed = rev_spd;
                        end else if (lft >= rgt) begin
                           set_mode(MODE_LEFT, q.now_ms);
                           a.motor_cmd   = CMD_ROTL;
                           a.motor_speed = turn_spd;
                        end else begin
                           set_mode(MODE_RIGHT, q.now_ms);
                           a.motor_cmd   = CMD_ROTR;
                           a.motor_speed = turn_spd;
                        end
                     end
                  end
                  MODE_REV: begin
                     if (el >= 32'(rev_time)) begin
                        set_mode(back_then_left ? MODE_LEFT : MODE_RIGHT, q.now_ms);
                        a.motor_cmd   = back_then_left ? CMD_ROTL : CMD_ROTR;
                        a.motor_speed = turn_spd;
                     end
                  end
                  MODE_LEFT, MODE_RIGHT: begin
                     if (el >= 32'(turn_time)) begin
                        a.motor_cmd = CMD_BRAKE;
                        set_mode(MODE_STOP, q.now_ms);
                     end
                  end
                  MODE_BLOCK: begin
                     a.motor_cmd = CMD_BRAKE;
                     if (cc > min_dist) set_mode(MODE_STOP, q.now_ms);
                  end
                  default: begin
                  end
               endcase
               // no forward progress for too long
               if ((q.now_ms - progress_at) > 32'(stuck_time) &&
                   cur_mode == MODE_FWD && cc <= slow_dist) begin
                  a.motor_cmd   = CMD_BRAKE;
                  a.motor_speed = 8'd0;
                  set_mode(MODE_BLOCK, q.now_ms);
               end
            end
         end
      endcase
      if (a.motor_cmd == CMD_BRAKE || a.motor_cmd == CMD_EMERG) a.motor_speed = 8'd0;
      a.mode = cur_mode;
      return a;
   endfunction

   function automatic req_type mk(input op_type op, input logic [31:0] t,
                                  input logic [15:0] c, input logic [1:0] hv,
                                  input logic [15:0] l, input logic lv,
                                  input logic [15:0] r, input logic rv);
      req_type q;
      q.opcode         = op;
      q.now_ms         = t;
      q.center_dist    = c;
      q.center_healthy = hv[1];
      q.center_valid   = hv[0];
      q.left_dist      = l;
      q.left_valid     = lv;
      q.right_dist     = r;
      q.right_valid    = rv;
      return q;
   endfunction

   function automatic void add_row(input req_type q);
      plan.push_back('{q, 1'b0, '0});
   endfunction

   function automatic void add_fixed(input req_type q, input mode_type m, input cmd_type c);
      rsp_type w;
      w.mode        = m;
      w.motor_cmd   = c;
      w.motor_speed = 8'd0;
      plan.push_back('{q, 1'b1, w});
   endfunction

   // distances clustered around the thresholds, with some anywhere
   function automatic logic [15:0] pick_dist();
      int base;
      case ($urandom_range(0, 5))
         0: base = int'(min_dist) + int'($urandom_range(0, 6)) - 3;
         1: base = int'(min_dist) +
                   int'($urandom_range(0, (slow_dist > min_dist) ? slow_dist - min_dist : 0));
         2: base = int'(slow_dist) + int'($urandom_range(0, 6)) - 3;
         3: base = int'(slow_dist) + int'($urandom_range(1, 3000));
         4: base = $urandom_range(0, 1) ? 65535 : 0;
         default: base = int'($urandom_range(0, 65535));
      endcase
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      return 16'(base);
   endfunction

   function automatic req_type random_cmd();
      op_type     op;
      logic [1:0] hv;
      int         pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) stamp = $urandom;
      else if (pick < 3) stamp = stamp + $urandom_range(0, 70000);
      else stamp = stamp + $urandom_range(0, 300);
      pick = $urandom_range(0, 99);
      if (pick < 86) op = OP_UPDATE;
      else if (pick < 92) op = OP_START;
      else if (pick < 96) op = OP_STOP;
      else op = OP_ESTOP;
      hv = 2'b11;
      if ($urandom_range(0, 19) == 0) hv = 2'($urandom_range(0, 2));
      return mk(op, stamp, pick_dist(), hv, pick_dist(), $urandom_range(0, 7) != 0,
                pick_dist(), $urandom_range(0, 7) != 0);
   endfunction

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MIN_DIST:   min_dist   = val;
         CSR_SLOW_DIST:  slow_dist  = val;
         CSR_CRUISE_SPD: cruise_spd = val[7:0];
         CSR_REV_SPD:    rev_spd    = val[7:0];
         CSR_TURN_SPD:   turn_spd   = val[7:0];
         CSR_REV_TIME:   rev_time   = val;
         CSR_TURN_TIME:  turn_time  = val;
         CSR_STUCK_TIME: stuck_time = val;
         default: begin
         end
      endcase
   endtask

   task automatic load_settings(input logic [15:0] md, input logic [15:0] sd,
                                input logic [7:0] cs, input logic [7:0] rs,
                                input logic [7:0] ts, input logic [15:0] rt,
                                input logic [15:0] tt, input logic [15:0] st);
      write_reg(CSR_MIN_DIST, md);
      write_reg(CSR_SLOW_DIST, sd);
      write_reg(CSR_CRUISE_SPD, {8'd0, cs});
      write_reg(CSR_REV_SPD, {8'd0, rs});
      write_reg(CSR_TURN_SPD, {8'd0, ts});
      write_reg(CSR_REV_TIME, rt);
      write_reg(CSR_TURN_TIME, tt);
      write_reg(CSR_STUCK_TIME, st);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_cmd(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type got;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // transaction accepted at this edge
      got = drive_decision(item);
      if (typed) got = want;
      pending_rsp.push_back(got);
      modes_hit[got.mode] = 1'b1;
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_rsp.size() == 0) begin
            faults++;
            if (faults <= REPORT_MAX)
               $display("unexpected result: mode %0d cmd %0d speed %0d",
                        rsp_data.mode, rsp_data.motor_cmd, rsp_data.motor_speed);
         end else begin
            want = pending_rsp.pop_front();
            checked++;
            if (rsp_data.mode !== want.mode || rsp_data.motor_cmd !== want.motor_cmd ||
                rsp_data.motor_speed !== want.motor_speed) begin
               faults++;
               if (faults <= REPORT_MAX)
                  $display("result %0d: expected mode %0d cmd %0d speed %0d, got %0d %0d %0d",
                           checked, want.mode, want.motor_cmd, want.motor_speed,
                           rsp_data.mode, rsp_data.motor_cmd, rsp_data.motor_speed);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int          p;
      logic [15:0] md;
      min_dist       = 16'd320;
      slow_dist      = 16'd800;
      cruise_spd     = 8'd160;
      rev_spd        = 8'd140;
      turn_spd       = 8'd150;
      rev_time       = 16'd600;
      turn_time      = 16'd450;
      stuck_time     = 16'd5000;
      cur_mode       = MODE_STOP;
      mode_since     = '0;
      progress_at    = '0;
      back_then_left = 1'b0;
      stamp          = 32'd100;

      // directed walk through the modes under reset settings
      add_fixed(mk(OP_START, 32'd1000, 16'd0, 2'b11, 16'd0, 1'b0, 16'd0, 1'b0),
                MODE_STOP, CMD_BRAKE);
      add_row(mk(OP_UPDATE, 32'd1010, 16'hFFFF, 2'b11, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1020, 16'd800, 2'b11, 16'd900, 1'b1, 16'd900, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1030, 16'd500, 2'b11, 16'd900, 1'b1, 16'd900, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1040, 16'd801, 2'b11, 16'd900, 1'b1, 16'd900, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1050, 16'd0, 2'b11, 16'd900, 1'b1, 16'd900, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1100, 16'd0, 2'b11, 16'd900, 1'b1, 16'd900, 1'b1));
      // left reading invalid, so it counts as zero and the turn goes right
      add_row(mk(OP_UPDATE, 32'd1170, 16'd0, 2'b11, 16'hFFFF, 1'b0, 16'd1000, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1620, 16'd0, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      add_row(mk(OP_UPDATE, 32'd1630, 16'd100, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      // both sides blocked: back up, then turn left
      add_row(mk(OP_UPDATE, 32'd1750, 16'd100, 2'b11, 16'd100, 1'b1, 16'd50, 1'b1));
      add_row(mk(OP_UPDATE, 32'd2350, 16'd100, 2'b11, 16'd100, 1'b1, 16'd50, 1'b1));
      add_fixed(mk(OP_ESTOP, 32'd2400, 16'd0, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1),
                MODE_EMERG, CMD_EMERG);
      add_fixed(mk(OP_UPDATE, 32'd2410, 16'hFFFF, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1),
                MODE_EMERG, CMD_NONE);
      add_fixed(mk(OP_STOP, 32'd2420, 16'd0, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1),
                MODE_STOP, CMD_BRAKE);
      add_fixed(mk(OP_UPDATE, 32'd2430, 16'hFFFF, 2'b01, 16'd0, 1'b1, 16'd0, 1'b1),
                MODE_BLOCK, CMD_BRAKE);
      add_fixed(mk(OP_UPDATE, 32'd2440, 16'hFFFF, 2'b10, 16'd0, 1'b1, 16'd0, 1'b1),
                MODE_BLOCK, CMD_BRAKE);
      add_row(mk(OP_UPDATE, 32'd2450, 16'd1000, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      // long after the last progress: forward is overruled by the stuck check
      add_row(mk(OP_UPDATE, 32'd9000, 16'd500, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      add_fixed(mk(OP_START, 32'hFFFF_FF00, 16'd0, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1),
                MODE_STOP, CMD_BRAKE);
      add_row(mk(OP_UPDATE, 32'hFFFF_FFF0, 16'hFFFF, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      add_row(mk(OP_UPDATE, 32'd16, 16'hFFFF, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      add_row(mk(OP_UPDATE, 32'd20, 16'd320, 2'b11, 16'd0, 1'b1, 16'd0, 1'b1));
      add_row(mk(OP_UPDATE, 32'd140, 16'd900, 2'b11, 16'd400, 1'b1, 16'd400, 1'b1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_cmd(plan[i].item, plan[i].typed, plan[i].want);
      drain();

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: load_settings(16'd320, 16'd800, 8'd160, 8'd140, 8'd150,
                             16'd600, 16'd450, 16'd5000);
            1: load_settings(16'd0, 16'hFFFF, 8'd255, 8'd255, 8'd255,
                             16'd0, 16'd0, 16'd0);
            2: load_settings(16'hFFFF, 16'd0, 8'd55, 8'd0, 8'd0,
                             16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: load_settings(16'd100, 16'd101, 8'd200, 8'd90, 8'd60,
                             16'd50, 16'd40, 16'd300);
            default: begin
               md = 16'($urandom_range(0, 3000));
               load_settings(md, md + 16'($urandom_range(1, 4000)),
                             8'($urandom_range(55, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 16'($urandom_range(0, 1500)),
                             16'($urandom_range(0, 1500)), 16'($urandom_range(200, 20000)));
            end
         endcase
         // no idling in the tight-threshold phase and in the closing phase
         calm = (p == 3 || p == PHASES - 1);
         repeat (PHASE_ITEMS) send_cmd(random_cmd(), 1'b0, '0);
         drain();
      end

      $display("%0d commands sent, %0d results checked over %0d register settings",
               sent, checked, PHASES + 1);
      $display("%0d of 9 drive modes reached, %0d faults", $countones(modes_hit), faults);
      if (faults == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
